@@ src/bpa_pkg.sv @@
package bpa_pkg;

  // fixed field widths
  localparam int START_W  = 16;
  localparam int LEN_W    = 17;
  localparam int FIRST_W  = 16;
  localparam int COUNT_W  = 17;
  localparam int TOTAL_W  = 17;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;

  // bits examined per cycle in a mixed bitmap word
  localparam int CHUNK_BITS = 8;

  // largest value of the free page counter
  localparam int COUNT_MAX = 131071;

  // register index as seen on paddr[2]
  localparam logic REG_PAGE_TOTAL = 1'b0;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_BAD_LEN   = 2'd1,
    RES_NO_RUN    = 2'd2,
    RES_BAD_RANGE = 2'd3
  } res_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_WORD,
    S_SCAN_CHUNK,
    S_MARK_STEP,
    S_MARK_WR,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      mem_rd;
    logic      mem_wr;
    logic      fill;
    logic      next_word;
    logic      run_clear;
    logic      run_add;
    logic      word_load;
    logic      chunk_step;
    logic      fin;
    res_code_t code;
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic alloc_bad;
    logic free_bad;
    logic word_in_limit;
    logic word_full;
    logic word_short;
    logic chunk_found;
    logic chunk_last;
    logic mark_done;
    logic mark_skip;
    logic clear_last;
    logic out_busy;
  } sts_t;

endpackage

@@ src/bpa_ctrl.sv @@
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output bpa_pkg::cmd_t cmd,
  input  bpa_pkg::sts_t sts
);
  import bpa_pkg::*;

  state_t state;
  state_t state_next;

  // state register, clearing pass first after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = RES_OK;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.mem_wr    = 1'b1;
        cmd.fill      = 1'b1;
        cmd.next_word = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_free) begin
          if (sts.free_bad) begin
            cmd.fin    = 1'b1;
            cmd.code   = RES_BAD_RANGE;
            state_next = S_DONE;
          end else begin
            state_next = S_MARK_STEP;
          end
        end else begin
          if (sts.alloc_bad) begin
            cmd.fin    = 1'b1;
            cmd.code   = RES_BAD_LEN;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (!sts.word_in_limit) begin
          cmd.fin    = 1'b1;
          cmd.code   = RES_NO_RUN;
          state_next = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_SCAN_WORD;
        end
      end
      S_SCAN_WORD: begin
        if (sts.word_full) begin
          cmd.run_clear = 1'b1;
          cmd.next_word = 1'b1;
          state_next    = S_SCAN_RD;
        end else if (sts.word_short) begin
          cmd.run_add   = 1'b1;
          cmd.next_word = 1'b1;
          state_next    = S_SCAN_RD;
        end else begin
          cmd.word_load = 1'b1;
          state_next    = S_SCAN_CHUNK;
        end
      end
      S_SCAN_CHUNK: begin
        cmd.chunk_step = 1'b1;
        if (sts.chunk_found) begin
          state_next = S_MARK_STEP;
        end else if (sts.chunk_last) begin
          cmd.next_word = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_MARK_STEP: begin
        if (sts.mark_done) begin
          cmd.fin    = 1'b1;
          cmd.code   = RES_OK;
          state_next = S_DONE;
        end else if (sts.mark_skip) begin
          cmd.next_word = 1'b1;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        cmd.mem_wr    = 1'b1;
        cmd.next_word = 1'b1;
        state_next    = S_MARK_STEP;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ src/bpa_dpath.sv @@
module bpa_dpath #(
  parameter int MAX_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bpa_pkg::cmd_t                 cmd,
  output bpa_pkg::sts_t                 sts,
  input  logic [bpa_pkg::TOTAL_W-1:0]   page_total,
  input  logic [bpa_pkg::IN_W-1:0]      s_tdata,  // start_page, run_length
  input  logic                          s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bpa_pkg::OUT_W-1:0]     m_tdata   // first_page, status, free_count
);
  import bpa_pkg::*;

  localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PAGE_W     = $clog2(MAX_PAGES + 1);
  localparam int SUM_W      = ((PAGE_W > LEN_W) ? PAGE_W : LEN_W) + 2;
  localparam int CHUNKS     = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CH_W       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int FREE_LIM_I = (MAX_PAGES < COUNT_MAX) ? MAX_PAGES : COUNT_MAX;
  localparam logic [COUNT_W-1:0] FREE_LIMIT = COUNT_W'(FREE_LIM_I);
  localparam logic [SUM_W-1:0]   WB         = SUM_W'(WORD_BITS);
  localparam logic [SUM_W-1:0]   MAXP       = SUM_W'(MAX_PAGES);
  localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

  // page bitmap, one bit per page, 1 = used
  logic [WORD_BITS-1:0] bitmap [WORD_COUNT];
  logic [WORD_BITS-1:0] mem_rdata;
  logic [WORD_BITS-1:0] wr_data;

  // request and walk registers
  logic                 action;
  logic [LEN_W-1:0]     len;
  logic [WORD_AW-1:0]   w;
  logic [SUM_W-1:0]     base;
  logic [SUM_W-1:0]     lo;
  logic [SUM_W-1:0]     hi;
  logic [LEN_W-1:0]     run;
  logic [SUM_W-1:0]     rs_page;
  logic [WORD_AW-1:0]   rs_word;
  logic [SUM_W-1:0]     rs_base;
  logic [WORD_BITS-1:0] word;
  logic [CH_W-1:0]      ch;
  logic [COUNT_W-1:0]   free_count;
  res_code_t            res_code;
  logic [FIRST_W-1:0]   res_first;

  // chunk scan results
  logic [CHUNKS*CHUNK_BITS-1:0] word_pad;
  logic [CHUNK_BITS-1:0]        chunk_bits;
  logic [LEN_W-1:0]             run_next;
  logic                         found;
  logic [SUM_W-1:0]             sp;
  logic [WORD_AW-1:0]           sw;
  logic [SUM_W-1:0]             sb;

  logic [SUM_W-1:0]     limit;
  logic [WORD_BITS-1:0] mask;
  logic [START_W-1:0]   in_start;
  logic [LEN_W-1:0]     in_len;

  assign in_start = s_tdata[START_W-1:0];
  assign in_len   = s_tdata[START_W+LEN_W-1:START_W];

  // page total clipped to the bitmap size
  assign limit = (SUM_W'(page_total) > MAXP) ? MAXP : SUM_W'(page_total);

  // bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_rdata <= bitmap[w];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      bitmap[w] <= wr_data;
    end
  end

  // range mask for the word under the walk pointer
  always_comb begin
    logic [SUM_W-1:0] pg;
    for (int i = 0; i < WORD_BITS; i++) begin
      pg      = base + SUM_W'(i);
      mask[i] = (pg >= lo) && (pg < hi);
    end
  end

  always_comb begin
    if (cmd.fill) begin
      wr_data = WORD_FULL;
    end else if (action == ACT_FREE) begin
      wr_data = mem_rdata & ~mask;
    end else begin
      wr_data = mem_rdata | mask;
    end
  end

  // one chunk of a mixed word, bit by bit
  always_comb begin
    word_pad                = '1;
    word_pad[WORD_BITS-1:0] = word;
    chunk_bits              = word_pad[CHUNK_BITS*ch +: CHUNK_BITS];
  end

  always_comb begin
    run_next = run;
    found    = 1'b0;
    sp       = rs_page;
    sw       = rs_word;
    sb       = rs_base;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      if ((int'(ch) * CHUNK_BITS + i < WORD_BITS) && !found) begin
        if (chunk_bits[i]) begin
          run_next = '0;
        end else begin
          if (run_next == '0) begin
            sp = base + SUM_W'(ch) * SUM_W'(CHUNK_BITS) + SUM_W'(i);
            sw = w;
            sb = base;
          end
          run_next = run_next + 1'b1;
          if (run_next == len) begin
            found = 1'b1;
          end
        end
      end
    end
  end

  // status towards the controller
  always_comb begin
    sts               = '0;
    sts.is_free       = (action == ACT_FREE);
    sts.alloc_bad     = (len == '0) || (len > free_count);
    sts.free_bad      = (hi > limit);
    sts.word_in_limit = (base + WB <= limit);
    sts.word_full     = (mem_rdata == WORD_FULL);
    sts.word_short    = (mem_rdata == '0) && (SUM_W'(run) + WB < SUM_W'(len));
    sts.chunk_found   = found;
    sts.chunk_last    = (ch == CH_W'(CHUNKS - 1));
    sts.mark_done     = (base >= hi);
    sts.mark_skip     = (base + WB <= lo);
    sts.clear_last    = (w == WORD_AW'(WORD_COUNT - 1));
    sts.out_busy      = m_tvalid && !m_tready;
  end

  // walk pointer and page base
  always_ff @(posedge clk) begin
    if (rst) begin
      w    <= '0;
      base <= '0;
    end else if (cmd.load) begin
      w    <= '0;
      base <= '0;
    end else if (cmd.chunk_step && found) begin
      w    <= sw;
      base <= sb;
    end else if (cmd.next_word) begin
      w    <= w + 1'b1;
      base <= base + WB;
    end
  end

  // request word, range and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= s_tuser;
      len    <= in_len;
      lo     <= SUM_W'(in_start);
      hi     <= SUM_W'(in_start) + SUM_W'(in_len);
      run    <= '0;
    end else begin
      if (cmd.run_clear) begin
        run <= '0;
      end else if (cmd.run_add) begin
        run <= run + LEN_W'(WORD_BITS);
      end else if (cmd.chunk_step) begin
        run <= run_next;
      end
      if (cmd.chunk_step) begin
        rs_page <= sp;
        rs_word <= sw;
        rs_base <= sb;
        if (found) begin
          lo <= sp;
          hi <= sp + SUM_W'(len);
        end
      end else if (cmd.run_add && run == '0) begin
        // an all-free word opens the run
        rs_page <= base;
        rs_word <= w;
        rs_base <= base;
      end
    end
    if (cmd.word_load) begin
      word <= mem_rdata;
      ch   <= '0;
    end else if (cmd.chunk_step) begin
      ch <= ch + 1'b1;
    end
  end

  // free count and result of the request
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
    end else if (cmd.fin && cmd.code == RES_OK) begin
      if (action == ACT_ALLOC) begin
        free_count <= free_count - len;
      end else if (len > FREE_LIMIT - free_count) begin
        free_count <= FREE_LIMIT;
      end else begin
        free_count <= free_count + len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_code <= cmd.code;
      if (cmd.code == RES_OK && action == ACT_ALLOC) begin
        res_first <= lo[FIRST_W-1:0];
      end else begin
        res_first <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= OUT_W'({free_count, res_code, res_first});
    end
  end

endmodule

@@ src/bitmap_page_allocator.sv @@
// channel   direction  contents
// s_axis    in         tdata: start_page, run_length; tuser: action
// m_axis    out        tdata: first_page, status, free_count
// apb       in/out     register 0 at byte 0: page_total (17 bits)
//
// one request in flight; a free request steps past the words below the
// range, then reads and writes each word it clears
// an allocate scans each free or used word whole and a mixed word in
// chunks of 8 bits, then reads and writes each word of the run to mark it
// after reset a clearing pass fills the bitmap, one word per cycle
// (1024 words at the default size); s_tready stays low meanwhile
// a finished word waits in the output register while the next is taken
module bitmap_page_allocator #(
  parameter int MAX_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bpa_pkg::IN_W-1:0]      s_tdata,  // start_page [15:0], run_length [32:16]
  input  logic                          s_tuser,  // action [0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bpa_pkg::OUT_W-1:0]     m_tdata,  // first_page [15:0], status [17:16],
                                                  // free_count [34:18]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpa_pkg::APB_W-1:0]     pwdata,
  output logic [bpa_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import bpa_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [TOTAL_W-1:0] page_total;
  logic               cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_total <= TOTAL_W'(65536);
    end else if (cfg_wr && paddr[2] == REG_PAGE_TOTAL) begin
      page_total <= pwdata[TOTAL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PAGE_TOTAL) ? APB_W'(page_total) : '0;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .page_total (page_total),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
